### rtl/cthb_pkg.sv
// Shared types and constants for the call trace history buffer.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package cthb_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int SIZE_W        = SLOT_W + 1;

    // Request codes on the func field.
    localparam logic [2:0] FN_TRACE      = 3'd0;
    localparam logic [2:0] FN_PAUSE      = 3'd1;
    localparam logic [2:0] FN_RESUME     = 3'd2;
    localparam logic [2:0] FN_READ_ALL   = 3'd3;
    localparam logic [2:0] FN_READ_FIRST = 3'd4;
    localparam logic [2:0] FN_READ_LAST  = 3'd5;
    localparam logic [2:0] FN_STATUS     = 3'd6;

    // Result kinds.
    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_IDLE   = 2'd3;

    // Configuration register indexes.
    localparam logic REG_TRACE_ENABLE = 1'b0;
    localparam logic REG_HISTORY_SIZE = 1'b1;

    // One stored history entry.
    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] caller;
        logic [2:0]  level;
        logic [7:0]  process;
        logic [31:0] repeats;
        logic [31:0] first_time;
        logic [31:0] latest_time;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_OUT,
        S_LRD,
        S_LDAT,
        S_LOUT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic list_rd;
        logic list_load;
    } ctl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic one_result;
        logic list;
        logic list_done;
    } dp_status_t;

endpackage

### rtl/cthb_ctrl.sv
// Sequencing state machine for the call trace history buffer.
// Depends on cthb_pkg; drives the datapath through ctl_cmd_t.
`timescale 1ns / 1ps

module cthb_ctrl
    import cthb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (status.one_result) state_next = S_OUT;
                else if (status.list) state_next = S_LRD;
                else state_next = S_IDLE;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            S_LRD: state_next = S_LDAT;
            S_LDAT: state_next = S_LOUT;
            S_LOUT: begin
                if (m_ready) state_next = status.list_done ? S_IDLE : S_LRD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_EXEC: cmd.exec = 1'b1;
            S_OUT: m_valid = 1'b1;
            S_LRD: cmd.list_rd = 1'b1;
            S_LDAT: cmd.list_load = 1'b1;
            S_LOUT: m_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

### rtl/cthb_datapath.sv
// Datapath of the call trace history buffer: entry memory, valid bits,
// counters, configuration and result register. Depends on cthb_pkg.
`timescale 1ns / 1ps

module cthb_datapath
    import cthb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  ctl_cmd_t          cmd,
    output dp_status_t        status,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic [2:0]        s_func,
    input  logic [31:0]       s_call_pc,
    input  logic [31:0]       s_caller_address,
    input  logic [2:0]        s_priority_level,
    input  logic [7:0]        s_process_id,
    input  logic [31:0]       s_now_time,
    input  logic [SIZE_W-1:0] s_read_count,
    output logic [1:0]        m_kind,
    output logic [SLOT_W-1:0] m_entry_index,
    output logic [31:0]       m_entry_pc,
    output logic [31:0]       m_entry_caller,
    output logic [2:0]        m_entry_level,
    output logic [7:0]        m_entry_process,
    output logic [31:0]       m_repeat_count,
    output logic [31:0]       m_first_time,
    output logic [31:0]       m_latest_time,
    output logic [31:0]       m_wrap_total,
    output logic [31:0]       m_missed_total,
    output logic              m_last
);

    entry_t mem [HISTORY_DEPTH];
    entry_t mem_q_reg;

    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [SLOT_W-1:0]        cur_reg;
    logic [31:0]              wrap_reg;
    logic [7:0]               pause_reg;
    logic [31:0]              missed_reg;
    logic                     enable_reg;
    logic [SIZE_W-1:0]        size_reg;

    logic [2:0]        func_reg;
    entry_t            in_reg;
    logic [SIZE_W-1:0] n_reg;

    logic [SLOT_W-1:0] slot_reg;
    logic [SIZE_W-1:0] remain_reg;

    entry_t            out_entry_reg;
    logic [1:0]        kind_reg;
    logic [SLOT_W-1:0] index_reg;
    logic              last_reg;
    logic [31:0]       wrap_out_reg;
    logic [31:0]       missed_out_reg;

    // Request decode.
    logic is_trace, is_read, is_status, recorded, hit;
    logic [SIZE_W-1:0] cur_inc, quant, first;
    logic [SLOT_W-1:0] new_cur, wr_addr, first_slot;
    logic              wrap_step;
    logic [31:0]       missed_next, wrap_next;
    entry_t            wr_entry, ack_entry;
    logic              wr_en;
    logic [SIZE_W-1:0] size_clamped;

    always_comb begin
        is_trace  = (func_reg == FN_TRACE);
        is_status = (func_reg == FN_STATUS);
        is_read   = (func_reg == FN_READ_ALL) || (func_reg == FN_READ_FIRST)
                 || (func_reg == FN_READ_LAST);
        recorded  = is_trace && enable_reg && (pause_reg == 8'd0);
        hit       = valid_reg[cur_reg] && (mem_q_reg.pc == in_reg.pc);

        // Slot advance with wrap at the configured size.
        cur_inc   = {1'b0, cur_reg} + 1'b1;
        wrap_step = (cur_inc >= size_reg);
        new_cur   = wrap_step ? '0 : cur_inc[SLOT_W-1:0];

        wrap_next = wrap_reg;
        if (recorded && !hit && wrap_step && (wrap_reg != 32'hFFFF_FFFF))
            wrap_next = wrap_reg + 32'd1;
        missed_next = missed_reg;
        if (is_trace && enable_reg && (pause_reg != 8'd0)
                && (missed_reg != 32'hFFFF_FFFF))
            missed_next = missed_reg + 32'd1;

        // Entry to store: either a folded repeat or a fresh entry.
        if (hit) begin
            wr_entry = mem_q_reg;
            if (mem_q_reg.repeats != 32'hFFFF_FFFF)
                wr_entry.repeats = mem_q_reg.repeats + 32'd1;
            wr_entry.latest_time = in_reg.latest_time;
            wr_addr = cur_reg;
        end else begin
            wr_entry         = in_reg;
            wr_entry.repeats = 32'd1;
            wr_addr          = new_cur;
        end
        wr_en = cmd.exec && recorded;

        if (recorded) ack_entry = wr_entry;
        else if (valid_reg[cur_reg]) ack_entry = mem_q_reg;
        else ack_entry = '0;

        // Listing window, oldest first.
        first = (wrap_reg != 32'd0) ? cur_inc : {{(SIZE_W-1){1'b0}}, 1'b1};
        quant = (wrap_reg != 32'd0) ? size_reg : {1'b0, cur_reg};
        if ((func_reg != FN_READ_ALL) && (n_reg < quant)) quant = n_reg;
        if (func_reg == FN_READ_LAST) begin
            if (quant <= {1'b0, cur_reg}) first = cur_inc - quant;
            else first = size_reg - (quant - cur_inc);
        end
        first_slot = (first >= size_reg) ? '0 : first[SLOT_W-1:0];

        status.one_result = is_trace || is_status
                         || (is_read && (!enable_reg || (quant == '0)));
        status.list       = is_read && enable_reg && (quant != '0);
        status.list_done  = (remain_reg == '0);

        size_clamped = cfg_data;
        if (cfg_data == '0) size_clamped = {{(SIZE_W-1){1'b0}}, 1'b1};
        else if (cfg_data > SIZE_W'(HISTORY_DEPTH)) size_clamped = SIZE_W'(HISTORY_DEPTH);
    end

    // Entry memory: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_entry;
        if (cmd.capture) mem_q_reg <= mem[cur_reg];
        else if (cmd.list_rd) mem_q_reg <= mem[slot_reg];
    end

    // Control state, counters and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            cur_reg    <= '0;
            wrap_reg   <= '0;
            pause_reg  <= '0;
            missed_reg <= '0;
            enable_reg <= 1'b0;
            size_reg   <= SIZE_W'(HISTORY_DEPTH);
            slot_reg   <= '0;
            remain_reg <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_TRACE_ENABLE) begin
                    enable_reg <= cfg_data[0];
                end else begin
                    size_reg  <= size_clamped;
                    valid_reg <= '0;
                    cur_reg   <= '0;
                    wrap_reg  <= '0;
                end
            end
            if (cmd.exec) begin
                missed_reg <= missed_next;
                wrap_reg   <= wrap_next;
                if ((func_reg == FN_PAUSE) && (pause_reg != 8'hFF))
                    pause_reg <= pause_reg + 8'd1;
                if ((func_reg == FN_RESUME) && (pause_reg != 8'd0))
                    pause_reg <= pause_reg - 8'd1;
                if (recorded && !hit) begin
                    cur_reg            <= new_cur;
                    valid_reg[new_cur] <= 1'b1;
                end
                slot_reg   <= first_slot;
                remain_reg <= quant;
            end
            if (cmd.list_load) begin
                remain_reg <= remain_reg - 1'b1;
                slot_reg   <= ({1'b0, slot_reg} + 1'b1 >= size_reg)
                            ? '0 : slot_reg + 1'b1;
            end
        end
    end

    // Input capture and result register.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg           <= s_func;
            in_reg.pc          <= s_call_pc;
            in_reg.caller      <= s_caller_address;
            in_reg.level       <= s_priority_level;
            in_reg.process     <= s_process_id;
            in_reg.repeats     <= 32'd0;
            in_reg.first_time  <= s_now_time;
            in_reg.latest_time <= s_now_time;
            n_reg              <= s_read_count;
        end
        if (cmd.exec) begin
            wrap_out_reg   <= wrap_next;
            missed_out_reg <= missed_next;
            last_reg       <= 1'b1;
            out_entry_reg  <= '0;
            index_reg      <= '0;
            if (!enable_reg || (is_read && (quant == '0))) begin
                kind_reg <= KIND_IDLE;
            end else if (is_status) begin
                kind_reg  <= KIND_STATUS;
                index_reg <= cur_reg;
            end else begin
                kind_reg      <= KIND_ACK;
                index_reg     <= recorded ? wr_addr : cur_reg;
                out_entry_reg <= ack_entry;
            end
        end
        if (cmd.list_load) begin
            kind_reg       <= KIND_ENTRY;
            index_reg      <= slot_reg;
            out_entry_reg  <= valid_reg[slot_reg] ? mem_q_reg : '0;
            last_reg       <= (remain_reg == {{(SIZE_W-1){1'b0}}, 1'b1});
            wrap_out_reg   <= wrap_reg;
            missed_out_reg <= missed_reg;
        end
    end

    assign m_kind          = kind_reg;
    assign m_entry_index   = index_reg;
    assign m_entry_pc      = out_entry_reg.pc;
    assign m_entry_caller  = out_entry_reg.caller;
    assign m_entry_level   = out_entry_reg.level;
    assign m_entry_process = out_entry_reg.process;
    assign m_repeat_count  = out_entry_reg.repeats;
    assign m_first_time    = out_entry_reg.first_time;
    assign m_latest_time   = out_entry_reg.latest_time;
    assign m_wrap_total    = wrap_out_reg;
    assign m_missed_total  = missed_out_reg;
    assign m_last          = last_reg;

endmodule

### rtl/call_trace_history_buffer.sv
// Top level of the call trace history buffer.
// Depends on cthb_pkg, cthb_ctrl and cthb_datapath.
`timescale 1ns / 1ps

// Circular trace buffer of 64 entries with repeat folding. The result of a
// request is registered: the entry memory is read at the accepting edge,
// and the next edge updates the entry and loads the result register. Trace
// events, status and single-result requests pass through the idle, exec and
// output states, and a new request is accepted only once the result has
// been taken; pause and resume return to idle with no result. A listing
// delivers its entry beats one after another, as each entry goes through
// the single read port of the entry memory before the next is read.
// Configuration must be written through cfg_we, cfg_index and cfg_data only
// while the block is idle; the block does not enforce this. A history_size
// write clears the slot index, the wrap count and all entries.
module call_trace_history_buffer
    import cthb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_func,
    input  logic [31:0]       s_call_pc,
    input  logic [31:0]       s_caller_address,
    input  logic [2:0]        s_priority_level,
    input  logic [7:0]        s_process_id,
    input  logic [31:0]       s_now_time,
    input  logic [SIZE_W-1:0] s_read_count,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [SLOT_W-1:0] m_entry_index,
    output logic [31:0]       m_entry_pc,
    output logic [31:0]       m_entry_caller,
    output logic [2:0]        m_entry_level,
    output logic [7:0]        m_entry_process,
    output logic [31:0]       m_repeat_count,
    output logic [31:0]       m_first_time,
    output logic [31:0]       m_latest_time,
    output logic [31:0]       m_wrap_total,
    output logic [31:0]       m_missed_total,
    output logic              m_last
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    cthb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cthb_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_func           (s_func),
        .s_call_pc        (s_call_pc),
        .s_caller_address (s_caller_address),
        .s_priority_level (s_priority_level),
        .s_process_id     (s_process_id),
        .s_now_time       (s_now_time),
        .s_read_count     (s_read_count),
        .m_kind           (m_kind),
        .m_entry_index    (m_entry_index),
        .m_entry_pc       (m_entry_pc),
        .m_entry_caller   (m_entry_caller),
        .m_entry_level    (m_entry_level),
        .m_entry_process  (m_entry_process),
        .m_repeat_count   (m_repeat_count),
        .m_first_time     (m_first_time),
        .m_latest_time    (m_latest_time),
        .m_wrap_total     (m_wrap_total),
        .m_missed_total   (m_missed_total),
        .m_last           (m_last)
    );

endmodule
